### rtl/core/hexd_pkg.sv
// Package for the hex escape name decoder.
// Holds character constants, window sizing, hex digit helpers and the
// command and status structs shared by the controller and the datapath.
`timescale 1ns / 1ps

package hexd_pkg;

	localparam int WIN_DEPTH = 6;
	localparam int CNT_W = 3;

	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
	localparam logic [7:0] CH_X = 8'h78;

	typedef struct packed {
		logic accept;
		logic pop;
	} hexd_cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic             full;
		logic             esc;
		logic             count_one;
	} hexd_sts_t;

	function automatic logic hex_valid(input logic [7:0] c);
		logic ok;
		ok = ((c >= 8'h30) && (c <= 8'h39)) ||
			((c >= 8'h61) && (c <= 8'h66)) ||
			((c >= 8'h41) && (c <= 8'h46));
		return ok;
	endfunction

	function automatic logic [3:0] hex_nibble(input logic [7:0] c);
		logic [7:0] v;
		if (c <= 8'h39) begin
			v = c - 8'h30;
		end else if (c >= 8'h61) begin
			v = c - 8'h57;
		end else begin
			v = c - 8'h37;
		end
		return v[3:0];
	endfunction

endpackage

### rtl/core/hexd_datapath.sv
// Datapath of the hex escape name decoder: pending byte window, fill count,
// escape detection and the output register.
// Depends on hexd_pkg.
`timescale 1ns / 1ps

module hexd_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  hexd_pkg::hexd_cmd_t cmd,
	input  logic [7:0]        in_byte,
	input  logic              in_last,
	output hexd_pkg::hexd_sts_t sts,
	output logic [7:0]        out_byte,
	output logic              out_last
);

	logic [7:0] win_q [hexd_pkg::WIN_DEPTH];
	logic [7:0] win_d [hexd_pkg::WIN_DEPTH];
	logic [hexd_pkg::CNT_W-1:0] cnt_q;
	logic [hexd_pkg::CNT_W-1:0] cnt_d;
	logic [7:0] out_byte_q;
	logic       out_last_q;
	logic       esc;
	logic [7:0] decoded;
	logic       full;

	always_comb begin
		full = (cnt_q == hexd_pkg::CNT_W'(hexd_pkg::WIN_DEPTH));
		esc = (win_q[0] == hexd_pkg::CH_UNDERSCORE) && (win_q[1] == hexd_pkg::CH_X) &&
			hexd_pkg::hex_valid(win_q[2]) && hexd_pkg::hex_valid(win_q[3]) &&
			hexd_pkg::hex_valid(win_q[4]) && hexd_pkg::hex_valid(win_q[5]) &&
			(in_byte == hexd_pkg::CH_UNDERSCORE);
		decoded = {hexd_pkg::hex_nibble(win_q[4]), hexd_pkg::hex_nibble(win_q[5])};
		sts.count = cnt_q;
		sts.full = full;
		sts.esc = esc;
		sts.count_one = (cnt_q == hexd_pkg::CNT_W'(1));
	end

	always_comb begin
		for (int i = 0; i < hexd_pkg::WIN_DEPTH; i++) begin
			win_d[i] = win_q[i];
		end
		cnt_d = cnt_q;
		if (cmd.accept) begin
			if (full) begin
				if (esc) begin
					cnt_d = '0;
				end else begin
					for (int i = 0; i < hexd_pkg::WIN_DEPTH - 1; i++) begin
						win_d[i] = win_q[i+1];
					end
					win_d[hexd_pkg::WIN_DEPTH-1] = in_byte;
				end
			end else begin
				for (int i = 0; i < hexd_pkg::WIN_DEPTH; i++) begin
					if (cnt_q == hexd_pkg::CNT_W'(i)) begin
						win_d[i] = in_byte;
					end
				end
				cnt_d = cnt_q + hexd_pkg::CNT_W'(1);
			end
		end else if (cmd.pop) begin
			for (int i = 0; i < hexd_pkg::WIN_DEPTH - 1; i++) begin
				win_d[i] = win_q[i+1];
			end
			cnt_d = cnt_q - hexd_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < hexd_pkg::WIN_DEPTH; i++) begin
			win_q[i] <= win_d[i];
		end
		if (cmd.accept && full) begin
			out_byte_q <= esc ? decoded : win_q[0];
			out_last_q <= esc && in_last;
		end else if (cmd.pop) begin
			out_byte_q <= win_q[0];
			out_last_q <= (cnt_q == hexd_pkg::CNT_W'(1));
		end
	end

	assign out_byte = out_byte_q;
	assign out_last = out_last_q;

endmodule

### rtl/core/hexd_ctrl.sv
// Controller of the hex escape name decoder: input and output handshakes
// and the flush sequence at the end of a name.
// Depends on hexd_pkg.
`timescale 1ns / 1ps

module hexd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic              s_tlast,
	output logic              m_tvalid,
	input  logic              m_tready,
	input  hexd_pkg::hexd_sts_t sts,
	output hexd_pkg::hexd_cmd_t cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_FLUSH = 1'b1;

	logic state_q;
	logic state_d;
	logic m_tvalid_q;
	logic out_free;
	logic emit;

	always_comb begin
		out_free = !m_tvalid_q || m_tready;
		s_tready = (state_q == ST_IDLE) && out_free;
		cmd.accept = s_tvalid && s_tready;
		cmd.pop = (state_q == ST_FLUSH) && out_free;
		emit = (cmd.accept && sts.full) || cmd.pop;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.accept && s_tlast && !(sts.full && sts.esc)) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (cmd.pop && sts.count_one) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;

endmodule

### rtl/core/hex_escape_name_decoder_unit.sv
// Top level of the hex escape name decoder.
// A result is registered and presented in the cycle after the transfer that causes it.
// Throughput: one input byte per cycle while the output is free and no flush runs;
// a last byte closing no escape starts a flush of up to six bytes, one per cycle as the output frees.
// Reset: arst_n clears the fill count, the controller state and the output valid.
`timescale 1ns / 1ps

module hex_escape_name_decoder_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // Bits 7:0 are in_byte.
	input  logic       s_tlast,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // Bits 7:0 are out_byte.
	output logic       m_tlast
);

	hexd_pkg::hexd_cmd_t cmd;
	hexd_pkg::hexd_sts_t sts;

	hexd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	hexd_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_byte  (s_tdata),
		.in_last  (s_tlast),
		.sts      (sts),
		.out_byte (m_tdata),
		.out_last (m_tlast)
	);

`ifndef SYNTHESIS
	a_last_empties: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> sts.count == '0)
		else $error("Window not empty while the last byte of a name is presented.");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sts.count <= hexd_pkg::CNT_W'(hexd_pkg::WIN_DEPTH))
		else $error("Window fill count exceeds its depth.");

	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.accept && cmd.pop))
		else $error("Input transfer and flush pop in the same cycle.");
`endif

endmodule
